[hdl/astf_pkg.sv]
// shared types, constants and the arctangent table of the angular spectrum transfer stage
// no dependencies
package astf_pkg;

    localparam int MAX_DIM_DEF       = 4096;
    localparam int CORDIC_STAGES_DEF = 20;

    localparam int IDX_W   = 12;
    localparam int DIM_W   = 13;
    localparam int STEP_W  = 32;
    localparam int PS_W    = 48;
    localparam int SPEC_W  = 24;
    localparam int CFG_A_W = 3;
    localparam int ROOT_W  = 31;
    localparam int REM_W   = 61;
    localparam int XY_W    = 34;
    localparam int ANG_W   = 36;

    localparam logic [CFG_A_W-1:0] REG_GRID_WIDTH   = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_GRID_HEIGHT  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_X_RATIO_STEP = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_Y_RATIO_STEP = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_PHASE_SCALE  = 3'd4;

    localparam logic signed [XY_W-1:0] KINV_Q30 = 34'sd652032874;

    typedef struct packed {
        logic                     valid;
        logic                     evan;
        logic signed [SPEC_W-1:0] re;
        logic signed [SPEC_W-1:0] im;
    } t_side;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[hdl/astf_sqrt_cell.sv]
// one result bit of the digit-by-digit square root chain
// depends on astf_pkg
module astf_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  astf_pkg::t_side               i_side,
    input  logic [astf_pkg::REM_W-1:0]    i_rem,
    input  logic [astf_pkg::ROOT_W-1:0]   i_root,
    output astf_pkg::t_side               o_side,
    output logic [astf_pkg::REM_W-1:0]    o_rem,
    output logic [astf_pkg::ROOT_W-1:0]   o_root
);

    logic [astf_pkg::REM_W:0]    w_delta;
    logic [astf_pkg::REM_W-1:0]  n_rem;
    logic [astf_pkg::ROOT_W-1:0] n_root;
    astf_pkg::t_side             r_side;
    logic [astf_pkg::REM_W-1:0]  r_rem;
    logic [astf_pkg::ROOT_W-1:0] r_root;

    always_comb begin
        w_delta = ((astf_pkg::REM_W+1)'(i_root) << (BIT + 1))
                + ((astf_pkg::REM_W+1)'(1) << (2 * BIT));
        if ({1'b0, i_rem} >= w_delta) begin
            n_rem  = i_rem - w_delta[astf_pkg::REM_W-1:0];
            n_root = i_root | (astf_pkg::ROOT_W'(1) << BIT);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side.valid <= i_side.valid;
        end
        if (i_en) begin
            r_side.evan <= i_side.evan;
            r_side.re   <= i_side.re;
            r_side.im   <= i_side.im;
            r_rem       <= n_rem;
            r_root      <= n_root;
        end
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

[hdl/astf_cordic_cell.sv]
// one rotation stage of the phasor cordic chain
// depends on astf_pkg
module astf_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  astf_pkg::t_side                    i_side,
    input  logic                               i_flip,
    input  logic signed [astf_pkg::XY_W-1:0]   i_x,
    input  logic signed [astf_pkg::XY_W-1:0]   i_y,
    input  logic signed [astf_pkg::ANG_W-1:0]  i_ang,
    output astf_pkg::t_side                    o_side,
    output logic                               o_flip,
    output logic signed [astf_pkg::XY_W-1:0]   o_x,
    output logic signed [astf_pkg::XY_W-1:0]   o_y,
    output logic signed [astf_pkg::ANG_W-1:0]  o_ang
);

    logic signed [astf_pkg::ANG_W-1:0] w_atan;
    logic signed [astf_pkg::XY_W-1:0]  w_dx;
    logic signed [astf_pkg::XY_W-1:0]  w_dy;
    logic signed [astf_pkg::XY_W-1:0]  n_x;
    logic signed [astf_pkg::XY_W-1:0]  n_y;
    logic signed [astf_pkg::ANG_W-1:0] n_ang;
    astf_pkg::t_side                   r_side;
    logic                              r_flip;
    logic signed [astf_pkg::XY_W-1:0]  r_x;
    logic signed [astf_pkg::XY_W-1:0]  r_y;
    logic signed [astf_pkg::ANG_W-1:0] r_ang;

    always_comb begin
        w_atan = signed'({4'b0, astf_pkg::atan_turn(STAGE)});
        w_dx   = i_y >>> STAGE;
        w_dy   = i_x >>> STAGE;
        if (i_ang >= 0) begin
            n_x   = i_x - w_dx;
            n_y   = i_y + w_dy;
            n_ang = i_ang - w_atan;
        end else begin
            n_x   = i_x + w_dx;
            n_y   = i_y - w_dy;
            n_ang = i_ang + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side.valid <= i_side.valid;
        end
        if (i_en) begin
            r_side.evan <= i_side.evan;
            r_side.re   <= i_side.re;
            r_side.im   <= i_side.im;
            r_flip      <= i_flip;
            r_x         <= n_x;
            r_y         <= n_y;
            r_ang       <= n_ang;
        end
    end

    assign o_side = r_side;
    assign o_flip = r_flip;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_ang  = r_ang;

endmodule

[hdl/angular_spectrum_transfer_apply.sv]
// angular spectrum transfer stage: one spectrum bin in, one propagated bin out
// throughput one word per cycle while the output word is not stalled
// whole pipeline advances together; it holds while the output word is stalled
// reset clears the valid bits and sets grid sizes to 1, steps and phase scale to 0
// depends on astf_pkg, astf_sqrt_cell, astf_cordic_cell
module angular_spectrum_transfer_apply #(
    parameter int MAX_DIM       = astf_pkg::MAX_DIM_DEF,
    parameter int CORDIC_STAGES = astf_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [astf_pkg::CFG_A_W-1:0]         i_cfg_index,
    input  logic [astf_pkg::PS_W-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [astf_pkg::IDX_W-1:0]           i_col_index,
    input  logic [astf_pkg::IDX_W-1:0]           i_row_index,
    input  logic signed [astf_pkg::SPEC_W-1:0]   i_spec_re,
    input  logic signed [astf_pkg::SPEC_W-1:0]   i_spec_im,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [astf_pkg::SPEC_W-1:0]   o_out_re,
    output logic signed [astf_pkg::SPEC_W-1:0]   o_out_im,
    output logic                                 o_evanescent
);

    localparam int DW  = astf_pkg::DIM_W;
    localparam int RW  = astf_pkg::ROOT_W;
    localparam int MW  = 58;
    localparam int SW  = 60;
    localparam logic [16:0] MAX_DIM_V = 17'(MAX_DIM);

    // configuration
    logic [DW-1:0]                    r_grid_w;
    logic [DW-1:0]                    r_grid_h;
    logic [31:0]                      r_xstep;
    logic [31:0]                      r_ystep;
    logic signed [astf_pkg::PS_W-1:0] r_pscale;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= DW'(1);
            r_grid_h <= DW'(1);
            r_xstep  <= '0;
            r_ystep  <= '0;
            r_pscale <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                astf_pkg::REG_GRID_WIDTH:   r_grid_w <= i_cfg_data[DW-1:0];
                astf_pkg::REG_GRID_HEIGHT:  r_grid_h <= i_cfg_data[DW-1:0];
                astf_pkg::REG_X_RATIO_STEP: r_xstep  <= i_cfg_data[31:0];
                astf_pkg::REG_Y_RATIO_STEP: r_ystep  <= i_cfg_data[31:0];
                astf_pkg::REG_PHASE_SCALE:  r_pscale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_adv;
    logic r_out_valid;
    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;

    // stage 1: bin magnitude
    function automatic logic [DW-1:0] eff_size(input logic [DW-1:0] n);
        logic [DW-1:0] e;
        if (n == '0) begin
            e = DW'(1);
        end else if ({4'b0, n} > MAX_DIM_V) begin
            e = DW'(MAX_DIM);
        end else begin
            e = n;
        end
        return e;
    endfunction

    function automatic logic [DW:0] axis_mag(input logic [astf_pkg::IDX_W-1:0] idx,
                                             input logic [DW-1:0] n);
        logic [DW-1:0] half;
        logic [DW:0]   res;
        half = (n - DW'(1)) >> 1;
        res[DW] = {1'b0, idx} >= n;
        if ({1'b0, idx} <= half) begin
            res[DW-1:0] = {1'b0, idx};
        end else begin
            res[DW-1:0] = n - {1'b0, idx};
        end
        return res;
    endfunction

    logic [DW:0]     w_cm;
    logic [DW:0]     w_rm;
    astf_pkg::t_side r1_side;
    logic [DW-1:0]   r1_cmag;
    logic [DW-1:0]   r1_rmag;

    assign w_cm = axis_mag(i_col_index, eff_size(r_grid_w));
    assign w_rm = axis_mag(i_row_index, eff_size(r_grid_h));

    // stage 2: axis ratios
    astf_pkg::t_side r2_side;
    logic [44:0]     r2_rx;
    logic [44:0]     r2_ry;

    // stage 3: squares
    astf_pkg::t_side r3_side;
    logic [61:0]     r3_rx2;
    logic [61:0]     r3_ry2;

    // stage 4: remainder for the root
    logic [62:0]              w_r2;
    astf_pkg::t_side          r4_side;
    logic [astf_pkg::REM_W-1:0] r4_d;

    assign w_r2 = {1'b0, r3_rx2} + {1'b0, r3_ry2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.valid <= 1'b0;
            r2_side.valid <= 1'b0;
            r3_side.valid <= 1'b0;
            r4_side.valid <= 1'b0;
        end else if (w_adv) begin
            r1_side.valid <= i_valid;
            r2_side.valid <= r1_side.valid;
            r3_side.valid <= r2_side.valid;
            r4_side.valid <= r3_side.valid;
        end
        if (w_adv) begin
            r1_side.evan <= w_cm[DW] | w_rm[DW];
            r1_side.re   <= i_spec_re;
            r1_side.im   <= i_spec_im;
            r1_cmag      <= w_cm[DW-1:0];
            r1_rmag      <= w_rm[DW-1:0];

            r2_side.evan <= r1_side.evan;
            r2_side.re   <= r1_side.re;
            r2_side.im   <= r1_side.im;
            r2_rx        <= 45'(r1_cmag) * 45'(r_xstep);
            r2_ry        <= 45'(r1_rmag) * 45'(r_ystep);

            r3_side.evan <= r2_side.evan | (r2_rx > 45'(1 << 30)) | (r2_ry > 45'(1 << 30));
            r3_side.re   <= r2_side.re;
            r3_side.im   <= r2_side.im;
            r3_rx2       <= 62'(r2_rx[30:0]) * 62'(r2_rx[30:0]);
            r3_ry2       <= 62'(r2_ry[30:0]) * 62'(r2_ry[30:0]);

            r4_side.evan <= r3_side.evan | (w_r2 > (63'(1) << 60));
            r4_side.re   <= r3_side.re;
            r4_side.im   <= r3_side.im;
            r4_d         <= astf_pkg::REM_W'((63'(1) << 60) - w_r2);
        end
    end

    // square root chain, one result bit per cell
    astf_pkg::t_side            w_sq_side [0:RW];
    logic [astf_pkg::REM_W-1:0] w_sq_rem  [0:RW];
    logic [RW-1:0]              w_sq_root [0:RW];

    assign w_sq_side[0] = r4_side;
    assign w_sq_rem[0]  = r4_d;
    assign w_sq_root[0] = '0;

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        astf_sqrt_cell #(.BIT(RW - 1 - j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_side  (w_sq_side[j]),
            .i_rem   (w_sq_rem[j]),
            .i_root  (w_sq_root[j]),
            .o_side  (w_sq_side[j+1]),
            .o_rem   (w_sq_rem[j+1]),
            .o_root  (w_sq_root[j+1])
        );
    end

    // phase products, split over the root halves
    astf_pkg::t_side r5_side;
    logic signed [64:0] r5_p0;
    logic signed [63:0] r5_p1;

    // wrapped angle and half turn fold
    logic [63:0]        w_phase;
    logic signed [32:0] w_frac;
    logic signed [32:0] w_fold;
    logic               w_flip;
    astf_pkg::t_side    r6_side;
    logic               r6_flip;
    logic signed [astf_pkg::ANG_W-1:0] r6_ang;

    always_comb begin
        w_phase = 64'(r5_p0) + (64'(r5_p1) << 16);
        w_frac  = 33'(signed'(w_phase[53:22]));
        w_fold  = w_frac;
        w_flip  = 1'b0;
        if (w_frac > 33'sd1073741824) begin
            w_fold = w_frac - 33'sd2147483648;
            w_flip = 1'b1;
        end else if (w_frac < -33'sd1073741824) begin
            w_fold = w_frac + 33'sd2147483648;
            w_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_side.valid <= 1'b0;
            r6_side.valid <= 1'b0;
        end else if (w_adv) begin
            r5_side.valid <= w_sq_side[RW].valid;
            r6_side.valid <= r5_side.valid;
        end
        if (w_adv) begin
            r5_side.evan <= w_sq_side[RW].evan;
            r5_side.re   <= w_sq_side[RW].re;
            r5_side.im   <= w_sq_side[RW].im;
            r5_p0        <= 65'(r_pscale) * signed'({1'b0, w_sq_root[RW][15:0]});
            r5_p1        <= 64'(r_pscale) * signed'({1'b0, w_sq_root[RW][RW-1:16]});

            r6_side.evan <= r5_side.evan;
            r6_side.re   <= r5_side.re;
            r6_side.im   <= r5_side.im;
            r6_flip      <= w_flip;
            r6_ang       <= astf_pkg::ANG_W'(w_fold);
        end
    end

    // cordic chain
    astf_pkg::t_side                   w_cd_side [0:CORDIC_STAGES];
    logic                              w_cd_flip [0:CORDIC_STAGES];
    logic signed [astf_pkg::XY_W-1:0]  w_cd_x    [0:CORDIC_STAGES];
    logic signed [astf_pkg::XY_W-1:0]  w_cd_y    [0:CORDIC_STAGES];
    logic signed [astf_pkg::ANG_W-1:0] w_cd_ang  [0:CORDIC_STAGES];

    assign w_cd_side[0] = r6_side;
    assign w_cd_flip[0] = r6_flip;
    assign w_cd_x[0]    = astf_pkg::KINV_Q30;
    assign w_cd_y[0]    = '0;
    assign w_cd_ang[0]  = r6_ang;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        astf_cordic_cell #(.STAGE(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_side  (w_cd_side[k]),
            .i_flip  (w_cd_flip[k]),
            .i_x     (w_cd_x[k]),
            .i_y     (w_cd_y[k]),
            .i_ang   (w_cd_ang[k]),
            .o_side  (w_cd_side[k+1]),
            .o_flip  (w_cd_flip[k+1]),
            .o_x     (w_cd_x[k+1]),
            .o_y     (w_cd_y[k+1]),
            .o_ang   (w_cd_ang[k+1])
        );
    end

    // complex product
    logic signed [astf_pkg::XY_W-1:0] w_cx;
    logic signed [astf_pkg::XY_W-1:0] w_cy;
    astf_pkg::t_side                  r7_side;
    logic signed [MW-1:0]             r7_rx;
    logic signed [MW-1:0]             r7_iy;
    logic signed [MW-1:0]             r7_ry;
    logic signed [MW-1:0]             r7_ix;

    assign w_cx = w_cd_flip[CORDIC_STAGES] ? -w_cd_x[CORDIC_STAGES] : w_cd_x[CORDIC_STAGES];
    assign w_cy = w_cd_flip[CORDIC_STAGES] ? -w_cd_y[CORDIC_STAGES] : w_cd_y[CORDIC_STAGES];

    function automatic logic signed [astf_pkg::SPEC_W-1:0] round_sat(
        input logic signed [SW-1:0] v);
        logic signed [SW-1:0] s;
        logic signed [astf_pkg::SPEC_W-1:0] o;
        s = (v + SW'(1 << 29)) >>> 30;
        if (s > SW'(8388607)) begin
            o = 24'sh7FFFFF;
        end else if (s < -SW'(8388608)) begin
            o = 24'sh800000;
        end else begin
            o = s[astf_pkg::SPEC_W-1:0];
        end
        return o;
    endfunction

    logic signed [astf_pkg::SPEC_W-1:0] r_out_re;
    logic signed [astf_pkg::SPEC_W-1:0] r_out_im;
    logic                               r_out_evan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_side.valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (w_adv) begin
            r7_side.valid <= w_cd_side[CORDIC_STAGES].valid;
            r_out_valid   <= r7_side.valid;
        end
        if (w_adv) begin
            r7_side.evan <= w_cd_side[CORDIC_STAGES].evan;
            r7_side.re   <= w_cd_side[CORDIC_STAGES].re;
            r7_side.im   <= w_cd_side[CORDIC_STAGES].im;
            r7_rx        <= MW'(w_cd_side[CORDIC_STAGES].re) * MW'(w_cx);
            r7_iy        <= MW'(w_cd_side[CORDIC_STAGES].im) * MW'(w_cy);
            r7_ry        <= MW'(w_cd_side[CORDIC_STAGES].re) * MW'(w_cy);
            r7_ix        <= MW'(w_cd_side[CORDIC_STAGES].im) * MW'(w_cx);

            r_out_evan <= r7_side.evan;
            if (r7_side.evan) begin
                r_out_re <= '0;
                r_out_im <= '0;
            end else begin
                r_out_re <= round_sat(SW'(r7_rx) - SW'(r7_iy));
                r_out_im <= round_sat(SW'(r7_ry) + SW'(r7_ix));
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_re     = r_out_re;
    assign o_out_im     = r_out_im;
    assign o_evanescent = r_out_evan;

endmodule
